// ===== rtl/core/rbe_pkg.sv =====
// Shared types and fixed field widths for the byte-wise rANS encoder.
package rbe_pkg;

  localparam int SYM_W   = 8;
  localparam int FREQ_W  = 13;
  localparam int START_W = 12;
  localparam int STATE_W = 32;
  localparam int BYTE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int ENTRY_W = FREQ_W + START_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_RENORM,
    ST_DIVIDE,
    ST_FLUSH,
    ST_ERROR
  } state_e;

  typedef struct packed {
    logic [FREQ_W-1:0]  freq;
    logic [START_W-1:0] start;
  } entry_t;

endpackage

// ===== rtl/core/rbe_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module rbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbe_div.sv =====
// Restoring divider: one quotient bit per cycle, state word by frequency.
module rbe_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rbe_pkg::STATE_W-1:0]  dividend_i,
  input  logic [rbe_pkg::FREQ_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [rbe_pkg::STATE_W-1:0]  quot_o,
  output logic [rbe_pkg::FREQ_W-1:0]   rem_o
);

  localparam int CNT_W = $clog2(rbe_pkg::STATE_W);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [rbe_pkg::STATE_W-1:0]  quot_q, quot_d;
  logic [rbe_pkg::FREQ_W-1:0]   rem_q, rem_d;
  logic [rbe_pkg::FREQ_W-1:0]   div_q, div_d;
  logic [rbe_pkg::FREQ_W:0]     trial;
  logic [rbe_pkg::FREQ_W:0]     diff;
  logic                         fits;

  // Bring down the next dividend bit and try to subtract.
  assign trial = {rem_q, quot_q[rbe_pkg::STATE_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[rbe_pkg::STATE_W-2:0], fits};
      rem_d  = fits ? diff[rbe_pkg::FREQ_W-1:0] : trial[rbe_pkg::FREQ_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(rbe_pkg::STATE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/rans_byte_encoder_top.sv =====
// Top level of the byte-wise 32-bit rANS encoder with a stored symbol table.
//
// The symbol table (frequency and cumulative start per symbol) lives in one
// synchronous RAM of TABLE_DEPTH entries. After reset the block first sweeps
// the RAM to zero, one entry a cycle, and stalls input until the sweep is
// done. A load transaction writes one entry; a load of a symbol at or beyond
// TABLE_DEPTH is dropped. An encode transaction reads its entry, then emits
// one low state byte per cycle while the output is not stalled and the state
// is at or above freq << (LOWER_BOUND_BITS - SCALE_BITS + 8). It then runs
// the restoring divider and, when the divider is done, commits the new state
// (state / freq << SCALE_BITS) + state % freq + start. An encode emits at
// most two renormalisation bytes, since the bound is at least 1 << 19. A
// symbol with zero (or unreachable) frequency yields a single error
// transaction and leaves the state alone. A flush emits the four state
// bytes, high byte first, and returns the state to 1 << LOWER_BOUND_BITS.
// Results leave through an output register, so a new input is taken while
// the final result still waits. Items are worked on one at a time;
// last_byte marks the final byte of a renormalisation run or a flush.
module rans_byte_encoder_top #(
  parameter int SCALE_BITS       = 12,
  parameter int LOWER_BOUND_BITS = 23,
  parameter int TABLE_DEPTH      = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rbe_pkg::MODE_W-1:0]   mode_i,
  input  logic [rbe_pkg::SYM_W-1:0]    symbol_i,
  input  logic [rbe_pkg::FREQ_W-1:0]   sym_freq_i,
  input  logic [rbe_pkg::START_W-1:0]  cum_start_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rbe_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         last_byte_o,
  output logic                         zero_freq_error_o
);

  localparam int AW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW       = ((AW > rbe_pkg::SYM_W) ? AW : rbe_pkg::SYM_W) + 1;
  localparam int BSH      = LOWER_BOUND_BITS - SCALE_BITS + 8;
  localparam int BW       = rbe_pkg::FREQ_W + BSH;
  localparam int CMPW     = (BW > rbe_pkg::STATE_W) ? BW : rbe_pkg::STATE_W;
  localparam logic [rbe_pkg::STATE_W-1:0] LOWER_BOUND =
    rbe_pkg::STATE_W'(1) << LOWER_BOUND_BITS;

  rbe_pkg::state_e              state_q, state_d;
  logic [rbe_pkg::STATE_W-1:0]  coder_q, coder_d;
  logic [rbe_pkg::FREQ_W-1:0]   freq_q, freq_d;
  logic [rbe_pkg::START_W-1:0]  start_q, start_d;
  logic                         range_q, range_d;
  logic [1:0]                   cnt_q, cnt_d;
  logic [AW-1:0]                clr_q, clr_d;

  logic                         out_valid_q, out_valid_d;
  logic [rbe_pkg::BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                         out_last_q, out_last_d;
  logic                         out_err_q, out_err_d;

  // Transaction strobes and table index.
  logic                         in_acc;
  logic [IW-1:0]                sym_ext;
  logic                         sym_in_range;
  logic [AW-1:0]                sym_addr;

  // RAM port.
  logic                         ram_we;
  logic [AW-1:0]                ram_addr;
  rbe_pkg::entry_t              ram_wdata;
  rbe_pkg::entry_t              ram_rdata;
  logic [rbe_pkg::FREQ_W-1:0]   lk_freq;

  // Renormalisation compare.
  logic [CMPW-1:0]              bound;
  logic                         above_bound;
  logic                         last_shift;

  // Result request towards the output register.
  logic                         emit_req;
  logic [rbe_pkg::BYTE_W-1:0]   emit_byte;
  logic                         emit_last;
  logic                         emit_err;
  logic                         emit_go;

  // Divider.
  logic                         div_start;
  logic                         div_done;
  logic [rbe_pkg::STATE_W-1:0]  div_quot;
  logic [rbe_pkg::FREQ_W-1:0]   div_rem;
  logic [rbe_pkg::STATE_W-1:0]  new_state;

  assign in_stall_o   = (state_q != rbe_pkg::ST_IDLE);
  assign in_acc       = in_valid_i && !in_stall_o;
  assign sym_ext      = IW'(symbol_i);
  assign sym_in_range = sym_ext < IW'(TABLE_DEPTH);
  assign sym_addr     = sym_ext[AW-1:0];

  // Out-of-table symbols read as zero frequency.
  assign lk_freq = range_q ? ram_rdata.freq : '0;

  assign bound       = CMPW'(freq_q) << BSH;
  assign above_bound = CMPW'(coder_q) >= bound;
  assign last_shift  = CMPW'(coder_q >> 8) < bound;

  // Advance the output register whenever it is empty or being drained.
  assign emit_go = emit_req && (!out_valid_q || !out_stall_i);

  assign new_state = (div_quot << SCALE_BITS) + rbe_pkg::STATE_W'(div_rem)
                   + rbe_pkg::STATE_W'(start_q);

  rbe_ram #(
    .WIDTH (rbe_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  rbe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (coder_q),
    .divisor_i  (freq_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbe_pkg::ST_CLEAR: begin
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = rbe_pkg::ST_IDLE;
        end
      end
      rbe_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            rbe_pkg::MODE_ENCODE: state_d = rbe_pkg::ST_LOOKUP;
            rbe_pkg::MODE_FLUSH:  state_d = rbe_pkg::ST_FLUSH;
            default:              state_d = rbe_pkg::ST_IDLE;
          endcase
        end
      end
      rbe_pkg::ST_LOOKUP: begin
        state_d = (lk_freq == '0) ? rbe_pkg::ST_ERROR : rbe_pkg::ST_RENORM;
      end
      rbe_pkg::ST_RENORM: begin
        if (!above_bound) begin
          state_d = rbe_pkg::ST_DIVIDE;
        end
      end
      rbe_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = rbe_pkg::ST_IDLE;
        end
      end
      rbe_pkg::ST_FLUSH: begin
        if (emit_go && cnt_q == 2'd3) begin
          state_d = rbe_pkg::ST_IDLE;
        end
      end
      rbe_pkg::ST_ERROR: begin
        if (emit_go) begin
          state_d = rbe_pkg::ST_IDLE;
        end
      end
      default: state_d = rbe_pkg::ST_IDLE;
    endcase
  end

  // State outputs: RAM port, divider start and result requests.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = sym_addr;
    ram_wdata = '{freq: sym_freq_i, start: cum_start_i};
    div_start = 1'b0;
    emit_req  = 1'b0;
    emit_byte = '0;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    case (state_q)
      rbe_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
      end
      rbe_pkg::ST_IDLE: begin
        ram_we = in_acc && (mode_i == rbe_pkg::MODE_LOAD) && sym_in_range;
      end
      rbe_pkg::ST_RENORM: begin
        emit_req  = above_bound;
        emit_byte = coder_q[rbe_pkg::BYTE_W-1:0];
        emit_last = last_shift;
        div_start = !above_bound;
      end
      rbe_pkg::ST_FLUSH: begin
        emit_req  = 1'b1;
        emit_last = (cnt_q == 2'd3);
        case (cnt_q)
          2'd0:    emit_byte = coder_q[31:24];
          2'd1:    emit_byte = coder_q[23:16];
          2'd2:    emit_byte = coder_q[15:8];
          default: emit_byte = coder_q[7:0];
        endcase
      end
      rbe_pkg::ST_ERROR: begin
        emit_req = 1'b1;
        emit_err = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    coder_d = coder_q;
    freq_d  = freq_q;
    start_d = start_q;
    range_d = range_q;
    cnt_d   = cnt_q;
    clr_d   = clr_q;
    if (state_q == rbe_pkg::ST_CLEAR) begin
      clr_d = clr_q + AW'(1);
    end
    if (in_acc) begin
      range_d = sym_in_range;
      cnt_d   = '0;
    end
    if (state_q == rbe_pkg::ST_LOOKUP) begin
      freq_d  = lk_freq;
      start_d = ram_rdata.start;
    end
    // Drop the emitted low byte during renormalisation.
    if (state_q == rbe_pkg::ST_RENORM && emit_go) begin
      coder_d = coder_q >> 8;
    end
    if (state_q == rbe_pkg::ST_FLUSH && emit_go) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        coder_d = LOWER_BOUND;
      end
    end
    if (state_q == rbe_pkg::ST_DIVIDE && div_done) begin
      coder_d = new_state;
    end
  end

  // Output register: load on a granted request, clear once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_go) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
      out_err_d   = emit_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbe_pkg::ST_CLEAR;
      coder_q     <= LOWER_BOUND;
      cnt_q       <= '0;
      clr_q       <= '0;
      range_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      coder_q     <= coder_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      range_q     <= range_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q     <= freq_d;
    start_q    <= start_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign last_byte_o       = out_last_q;
  assign zero_freq_error_o = out_err_q;

endmodule
